FILE: sv/rtdc_pkg.sv
`default_nettype none
package rtdc_pkg;

  localparam int CODE_BITS     = 15;
  localparam int FRACTION_BITS = 8;
  localparam int WORD_W        = CODE_BITS + 1;
  localparam int REF_W         = 22;
  localparam int NOM_W         = 19;
  localparam int RES_W         = 22;
  localparam int TEMP_W        = 19;

  // quadratic branch: root of floor(num * 2^(2F) / d), d = 53361 * r0
  localparam int QDIV_CELLS = 40;
  localparam int QREM_W     = 35;
  localparam int SQRT_CELLS = QDIV_CELLS / 2;
  localparam int SREM_W     = SQRT_CELLS + 1;
  localparam int QUAD_OFFSET = (781660 * (1 << FRACTION_BITS)) / 231;

  // polynomial branch: u = r * 100 * 2^16 / r0, capped below 100 * 2^16
  localparam int UDIV_CELLS = 23;
  localparam int UREM_W     = NOM_W;
  localparam logic [UDIV_CELLS-1:0] U_MAX = UDIV_CELLS'(100 * 65536 - 1);
  localparam int POLY_LAT   = 7;

  // pipeline stage map
  localparam int FRONT      = 3;
  localparam int LAST_STAGE = FRONT + QDIV_CELLS + SQRT_CELLS;
  localparam int TP_DELAY   = LAST_STAGE - (FRONT + UDIV_CELLS + POLY_LAT);

  localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
  localparam int TEMP_MIN = -(1 << (TEMP_W - 1));

  // horner coefficients, Q56 for r^5..r^3, Q48 for r^2, Q36 for r and constant
  localparam logic signed [24:0] K5 = 25'sd10983739;
  localparam logic signed [32:0] K4 = -33'sd2030799173;
  localparam logic signed [41:0] K3 = -42'sd347749948827;
  localparam logic signed [41:0] K2 = 42'sd727866042276;
  localparam logic signed [39:0] K1 = 40'sd152749652889;
  localparam logic signed [46:0] K0 = -47'sd16631487759647;

  typedef enum logic {
    REG_REFERENCE = 1'b0,
    REG_NOMINAL   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [QREM_W-1:0]     rem;
    logic [QDIV_CELLS-1:0] w;
  } qdiv_t;

  typedef struct packed {
    logic [SREM_W-1:0]     rem;
    logic [SQRT_CELLS-1:0] root;
    logic [QDIV_CELLS-1:0] w;
  } sqrt_t;

  typedef struct packed {
    logic [UREM_W-1:0]     rem;
    logic [UDIV_CELLS-1:0] w;
    logic                  ovf;
  } udiv_t;

  function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [47:0] v);
    logic signed [TEMP_W-1:0] res;
    if (v > $signed(48'(TEMP_MAX))) begin
      res = TEMP_W'(TEMP_MAX);
    end else if (v < $signed(48'(TEMP_MIN))) begin
      res = TEMP_W'(TEMP_MIN);
    end else begin
      res = v[TEMP_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rtdc_qdiv_cell.sv
`default_nettype none
module rtdc_qdiv_cell (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [rtdc_pkg::QREM_W-1:0] d,
  input  wire rtdc_pkg::qdiv_t       cell_in,
  output rtdc_pkg::qdiv_t            cell_out
);
  import rtdc_pkg::*;

  logic [QREM_W:0] trial;
  logic            ge;
  qdiv_t           cell_nxt;

  // one restoring step: dividend bits leave at the top, quotient bits enter below
  always_comb begin
    trial = {cell_in.rem, cell_in.w[QDIV_CELLS-1]};
    ge    = trial >= {1'b0, d};
    cell_nxt.rem = ge ? QREM_W'(trial - {1'b0, d}) : trial[QREM_W-1:0];
    cell_nxt.w   = {cell_in.w[QDIV_CELLS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rtdc_sqrt_cell.sv
`default_nettype none
module rtdc_sqrt_cell (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire rtdc_pkg::sqrt_t cell_in,
  output rtdc_pkg::sqrt_t      cell_out
);
  import rtdc_pkg::*;

  logic [SREM_W+1:0] trial;
  logic [SREM_W:0]   sub;
  logic              ge;
  sqrt_t             cell_nxt;

  // one root bit per cell, two radicand bits consumed
  always_comb begin
    trial = {cell_in.rem, cell_in.w[QDIV_CELLS-1:QDIV_CELLS-2]};
    sub   = {cell_in.root[SQRT_CELLS-2:0], 2'b01};
    ge    = trial >= {1'b0, sub};
    cell_nxt.rem  = ge ? SREM_W'(trial - {1'b0, sub}) : trial[SREM_W-1:0];
    cell_nxt.root = {cell_in.root[SQRT_CELLS-2:0], ge};
    cell_nxt.w    = {cell_in.w[QDIV_CELLS-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rtdc_udiv_cell.sv
`default_nettype none
module rtdc_udiv_cell (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [rtdc_pkg::UREM_W-1:0] r0,
  input  wire rtdc_pkg::udiv_t            cell_in,
  output rtdc_pkg::udiv_t                 cell_out
);
  import rtdc_pkg::*;

  logic [UREM_W:0] trial;
  logic            ge;
  udiv_t           cell_nxt;

  always_comb begin
    trial = {cell_in.rem, cell_in.w[UDIV_CELLS-1]};
    ge    = trial >= {1'b0, r0};
    cell_nxt.rem = ge ? UREM_W'(trial - {1'b0, r0}) : trial[UREM_W-1:0];
    cell_nxt.w   = {cell_in.w[UDIV_CELLS-2:0], ge};
    cell_nxt.ovf = cell_in.ovf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rtdc_poly.sv
`default_nettype none
module rtdc_poly (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [rtdc_pkg::UDIV_CELLS-1:0]   quot,
  input  wire logic                              ovf,
  output logic signed [rtdc_pkg::TEMP_W-1:0]     temp
);
  import rtdc_pkg::*;

  localparam int SHIFT_OUT = 36 - FRACTION_BITS;
  localparam logic signed [46:0] HALF = 47'(64'd1 << (SHIFT_OUT - 1));

  logic [UDIV_CELLS-1:0] u0_r, u1_r, u2_r, u3_r, u4_r;
  logic signed [32:0] a1_r;
  logic signed [41:0] a2_r, a3_r;
  logic signed [39:0] a4_r;
  logic signed [46:0] a5_r;

  logic signed [48:0] m1;
  logic signed [56:0] m2;
  logic signed [65:0] m3, m4;
  logic signed [63:0] m5;
  logic signed [46:0] rnd;

  always_comb begin
    m1  = K5 * $signed({1'b0, u0_r});
    m2  = a1_r * $signed({1'b0, u1_r});
    m3  = a2_r * $signed({1'b0, u2_r});
    m4  = a3_r * $signed({1'b0, u3_r});
    m5  = a4_r * $signed({1'b0, u4_r});
    rnd = (a5_r + HALF) >>> SHIFT_OUT;
  end

  // horner, one product per stage with floor shifts between scales
  always_ff @(posedge clk) begin
    if (en) begin
      u0_r <= (ovf || quot > U_MAX) ? U_MAX : quot;
      u1_r <= u0_r;
      a1_r <= 33'(K4 + (m1 >>> 16));
      u2_r <= u1_r;
      a2_r <= 42'(K3 + (m2 >>> 16));
      u3_r <= u2_r;
      a3_r <= 42'(K2 + (m3 >>> 24));
      u4_r <= u3_r;
      a4_r <= 40'(K1 + (m4 >>> 28));
      a5_r <= 47'(K0 + (m5 >>> 16));
      temp <= sat_temp(48'(rnd));
    end
  end

endmodule
`default_nettype wire

FILE: sv/rtd_code_to_temperature_top.sv
`default_nettype none
// RTD ratio code to resistance and temperature converter.
// Input channel: in_rtd_word (bits 15..1 ratio code, bit 0 fault), in_valid/in_stall.
// Result channel: out_resistance (1/256 ohm), out_temperature (1/256 degC, signed),
// out_fault, out_valid/out_stall. One result per transfer in, in order.
// Configuration: APB registers reference_ohms at 0x0 and nominal_ohms at 0x4;
// write them only while no transfer is in flight.
// Throughput: one transfer per cycle while out_stall does not hold the pipeline.
// The chain of 40 divider cells and 20 square-root cells sets the pipeline depth
// from the input transfer to out_valid, while the polynomial branch runs beside
// them and is delayed to meet the root at the last stage.
// A faulted word gives zero resistance and temperature with out_fault set.
// When out_valid is high and out_stall is high, the whole pipeline holds and
// in_stall is raised; nothing is dropped.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// registers: 430 ohm reference, 100 ohm nominal.
module rtd_code_to_temperature_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rtdc_pkg::WORD_W-1:0]       in_rtd_word,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rtdc_pkg::RES_W-1:0]             out_resistance,
  output logic signed [rtdc_pkg::TEMP_W-1:0]     out_temperature,
  output logic                                   out_fault,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import rtdc_pkg::*;

  logic [REF_W-1:0] ref_r;
  logic [NOM_W-1:0] nom_r;
  logic [NOM_W-1:0] r0;
  logic [49:0]      p1_r;
  logic [QREM_W-1:0] d_r;
  reg_idx_t         reg_sel;

  logic en;

  logic             v_r  [0:LAST_STAGE];
  logic             f_r  [0:LAST_STAGE];
  logic [RES_W-1:0] rs_r [1:LAST_STAGE];

  logic [CODE_BITS-1:0] code_r;
  logic [49:0]          p2_r;
  logic [28:0]          ru_r;
  logic [36:0]          rprod;
  logic [49:0]          diff;
  logic [58:0]          num;
  logic [21:0]          utop;

  qdiv_t qs [0:QDIV_CELLS];
  sqrt_t ss [0:SQRT_CELLS];
  udiv_t us [0:UDIV_CELLS];
  qdiv_t q_front_r;
  udiv_t u_front_r;

  logic signed [TEMP_W-1:0] tp [0:TP_DELAY];
  logic signed [TEMP_W-1:0] tpd_r [1:TP_DELAY];

  logic signed [SREM_W-1:0] quad_temp;
  logic signed [SREM_W-1:0] t_sel;

  logic                     out_valid_r;
  logic [RES_W-1:0]         out_res_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic                     out_fault_r;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_REFERENCE: prdata = 32'(ref_r);
      REG_NOMINAL:   prdata = 32'(nom_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_W'(110080);
      nom_r <= NOM_W'(25600);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_REFERENCE: ref_r <= pwdata[REF_W-1:0];
        REG_NOMINAL:   nom_r <= pwdata[NOM_W-1:0];
        default:       ;
      endcase
    end
  end

  assign r0 = (nom_r == '0) ? NOM_W'(1) : nom_r;

  // terms that depend on configuration only
  always_ff @(posedge clk) begin
    p1_r <= 31'd1758480889 * r0;
    d_r  <= 16'd53361 * r0;
  end

  // flow control: the pipeline moves as a whole unless the result is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST_STAGE; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= LAST_STAGE; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  assign rprod = code_r * ref_r;

  always_ff @(posedge clk) begin
    if (en) begin
      code_r   <= in_rtd_word[WORD_W-1:1];
      f_r[0]   <= in_rtd_word[0];
      rs_r[1]  <= rprod[CODE_BITS +: RES_W];
      for (int k = 1; k <= LAST_STAGE; k++) begin
        f_r[k] <= f_r[k-1];
      end
      for (int k = 2; k <= LAST_STAGE; k++) begin
        rs_r[k] <= rs_r[k-1];
      end
      p2_r <= 28'd231000000 * rs_r[1];
      ru_r <= 7'd100 * rs_r[1];
    end
  end

  // front of both dividers
  always_comb begin
    diff = p1_r - p2_r;
    num  = (p1_r > p2_r) ? 59'(diff) * 59'd400 : '0;
    utop = ru_r[28:7];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_front_r.rem <= num[58:24];
      q_front_r.w   <= {num[23:0], {(2 * FRACTION_BITS){1'b0}}};
      u_front_r.rem <= utop[UREM_W-1:0];
      u_front_r.w   <= {ru_r[6:0], 16'h0000};
      u_front_r.ovf <= utop >= 22'(r0);
    end
  end

  assign qs[0] = q_front_r;
  assign us[0] = u_front_r;

  for (genvar j = 0; j < QDIV_CELLS; j++) begin : g_qdiv
    rtdc_qdiv_cell u_cell (
      .clk      (clk),
      .en       (en),
      .d        (d_r),
      .cell_in  (qs[j]),
      .cell_out (qs[j+1])
    );
  end

  assign ss[0].rem  = '0;
  assign ss[0].root = '0;
  assign ss[0].w    = qs[QDIV_CELLS].w;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    rtdc_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .cell_in  (ss[j]),
      .cell_out (ss[j+1])
    );
  end

  for (genvar j = 0; j < UDIV_CELLS; j++) begin : g_udiv
    rtdc_udiv_cell u_cell (
      .clk      (clk),
      .en       (en),
      .r0       (r0),
      .cell_in  (us[j]),
      .cell_out (us[j+1])
    );
  end

  rtdc_poly u_poly (
    .clk  (clk),
    .en   (en),
    .quot (us[UDIV_CELLS].w),
    .ovf  (us[UDIV_CELLS].ovf),
    .temp (tp[0])
  );

  // polynomial result waits for the root
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= TP_DELAY; k++) begin
        tpd_r[k] <= tp[k-1];
      end
    end
  end

  for (genvar k = 1; k <= TP_DELAY; k++) begin : g_tp
    assign tp[k] = tpd_r[k];
  end

  always_comb begin
    quad_temp = $signed(SREM_W'(QUAD_OFFSET)) - $signed({1'b0, ss[SQRT_CELLS].root});
    t_sel     = (quad_temp < 0) ? SREM_W'(tp[TP_DELAY]) : quad_temp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[LAST_STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_fault_r <= f_r[LAST_STAGE];
      out_res_r   <= f_r[LAST_STAGE] ? '0 : rs_r[LAST_STAGE];
      out_temp_r  <= f_r[LAST_STAGE] ? '0 : sat_temp(48'(t_sel));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_resistance  = out_res_r;
  assign out_temperature = out_temp_r;
  assign out_fault       = out_fault_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_last_stage_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[LAST_STAGE]) |=> out_valid)
    else $error("item at last stage did not reach the output");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (out_resistance == '0 && out_temperature == '0))
    else $error("faulted result carries nonzero values");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rtdc_pkg::*;

  typedef struct {
    logic [RES_W-1:0]         resistance;
    logic signed [TEMP_W-1:0] temperature;
    logic                     fault;
  } reading_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [WORD_W-1:0]        in_rtd_word;
  logic                     out_valid;
  logic                     out_stall;
  logic [RES_W-1:0]         out_resistance;
  logic signed [TEMP_W-1:0] out_temperature;
  logic                     out_fault;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [2:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  logic [WORD_W-1:0] word_queue[$];
  reading_t          reading_queue[$];
  logic [REF_W-1:0]  ref_shadow;
  logic [NOM_W-1:0]  nom_shadow;
  int                mismatches;
  int                quiet_cycles;
  bit                steady;

  longint k5, k4, k3, k2, k1, k0;

  rtd_code_to_temperature_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rtd_word(in_rtd_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_resistance(out_resistance),
    .out_temperature(out_temperature), .out_fault(out_fault),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // fifth-order fit used below zero degC
  function automatic longint cold_temperature(longint unsigned r, longint unsigned r0);
    longint unsigned u;
    longint a;
    longint ui;
    u = ((r * 100) << 16) / r0;
    if (u > (64'd100 << 16) - 1) u = (64'd100 << 16) - 1;
    ui = longint'(u);
    a = k5;
    a = k4 + ((a * ui) >>> 16);
    a = k3 + ((a * ui) >>> 16);
    a = k2 + ((a * ui) >>> 24);
    a = k1 + ((a * ui) >>> 28);
    a = k0 + ((a * ui) >>> 16);
    return (a + (64'sd1 << (35 - FRACTION_BITS))) >>> (36 - FRACTION_BITS);
  endfunction

  function automatic reading_t convert_word(logic [WORD_W-1:0] w, logic [REF_W-1:0] ref_ohms,
                                            logic [NOM_W-1:0] nom_ohms);
    reading_t          e;
    longint unsigned   code;
    longint unsigned   r;
    longint unsigned   r0;
    longint unsigned   s;
    longint            n;
    longint            t;
    logic [127:0]      num;
    logic [127:0]      acc;
    e.resistance = '0;
    e.temperature = '0;
    e.fault = w[0];
    if (w[0]) return e;
    code = longint'(w[WORD_W-1:1]);
    r = (code * longint'(ref_ohms)) >> CODE_BITS;
    r0 = (nom_ohms == 0) ? 1 : longint'(nom_ohms);
    n = longint'(64'd1758480889 * r0) - longint'(64'd231000000 * r);
    s = 0;
    if (n > 0) begin
      num = 128'(n) * 400;
      acc = (num << (2 * FRACTION_BITS)) / 128'(64'd53361 * r0);
      s = floor_root(acc[63:0]);
    end
    t = longint'((64'd781660 << FRACTION_BITS) / 231) - longint'(s);
    if (t < 0) t = cold_temperature(r, r0);
    if (t > 262143) t = 262143;
    if (t < -262144) t = -262144;
    e.resistance = r[RES_W-1:0];
    e.temperature = t[TEMP_W-1:0];
    return e;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reading_queue.push_back(convert_word(in_rtd_word, ref_shadow, nom_shadow));
        void'(word_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (word_queue.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
        in_valid <= 1'b1;
        in_rtd_word <= word_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    reading_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reading_queue.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = reading_queue.pop_front();
          if (out_resistance !== e.resistance)
            report_mismatch($sformatf("resistance %0d, want %0d", out_resistance,
                                      e.resistance));
          if (out_temperature !== e.temperature)
            report_mismatch($sformatf("temperature %0d, want %0d", out_temperature,
                                      e.temperature));
          if (out_fault !== e.fault)
            report_mismatch($sformatf("fault %0b, want %0b", out_fault, e.fault));
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 30);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_REFERENCE) ref_shadow = value[REF_W-1:0];
    else nom_shadow = value[NOM_W-1:0];
  endtask

  task automatic drain;
    wait (word_queue.size() == 0 && reading_queue.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_words(int count);
    logic [WORD_W-1:0] w;
    repeat (count) begin
      w = WORD_W'($urandom);
      if ($urandom_range(9) != 0) w[0] = 1'b0;
      if ($urandom_range(3) == 0) w[WORD_W-1:1] = 15'($urandom_range(20000, 5000));
      word_queue.push_back(w);
    end
  endtask

  initial begin
    logic [REF_W-1:0] refs[7];
    logic [NOM_W-1:0] noms[7];
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rtd_word = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    ref_shadow = 22'd110080;
    nom_shadow = 19'd25600;
    k5 = longint'(round_div(64'd15243 << 42, 64'd6103515625));
    k4 = -longint'(round_div(64'd28183 << 44, 64'd244140625));
    k3 = -longint'(round_div(64'd4826 << 47, 64'd1953125));
    k2 = longint'(round_div(64'd25859 << 41, 64'd78125));
    k1 = longint'(round_div(64'd22228 << 32, 64'd625));
    k0 = -longint'(round_div(64'd24202 << 34, 64'd25));
    refs = '{22'd110080, 22'd2560000, 22'd256, 22'd2560000, 22'd256, 22'd4194303, 22'd110080};
    noms = '{19'd25600, 19'd512000, 19'd256, 19'd256, 19'd512000, 19'd0, 19'd524287};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset defaults: extremes, faults, both sides of zero degC
    word_queue.push_back(16'h0000);
    word_queue.push_back(16'hFFFE);
    word_queue.push_back(16'h0001);
    word_queue.push_back(16'hFFFF);
    word_queue.push_back(16'hAAAA);
    word_queue.push_back(16'h5554);
    word_queue.push_back(16'h3B9E);
    word_queue.push_back(16'h3B9C);
    word_queue.push_back(16'h2000);
    word_queue.push_back(16'h0002);
    word_queue.push_back(16'h8000);
    word_queue.push_back(16'h7FFE);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_REFERENCE, 32'(refs[p]));
      write_reg(REG_NOMINAL, 32'(noms[p]));
      word_queue.push_back(16'h0000);
      word_queue.push_back(16'hFFFE);
      word_queue.push_back(16'hFFFF);
      steady = (p == 3);
      random_words(245);
      drain();
      steady = 1'b0;
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/rtdc_pkg.sv
sv/rtdc_qdiv_cell.sv
sv/rtdc_sqrt_cell.sv
sv/rtdc_udiv_cell.sv
sv/rtdc_poly.sv
sv/rtd_code_to_temperature_top.sv
tb/sv/testbench.sv
